FILE: src/chip8_instruction_execute_top_assert.svh
// Assertion macros shared by the instruction execute block.
`ifndef CHIP8_INSTRUCTION_EXECUTE_TOP_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTE_TOP_ASSERT_SVH

// Checked on every rising clock edge outside of reset.
`define C8IE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define C8IE_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: src/c8ie_pkg.sv
package c8ie_pkg;

    localparam int INSTR_W   = 16;
    localparam int PC_W      = 12;
    localparam int REG_W     = 8;
    localparam int NUM_VREGS = 16;
    localparam int VIDX_W    = 4;

    localparam logic [PC_W-1:0]    PC_RESET = 12'h200;
    localparam logic [PC_W-1:0]    PC_STEP  = 12'd2;
    localparam logic [PC_W-1:0]    PC_SKIP  = 12'd4;
    localparam logic [VIDX_W-1:0]  VF_IDX   = 4'hF;

    localparam logic [INSTR_W-1:0] OPC_CLS  = 16'h00E0;
    localparam logic [INSTR_W-1:0] OPC_RET  = 16'h00EE;

    // Major opcode groups (top nibble).
    localparam logic [3:0] OP_SYS     = 4'h0;
    localparam logic [3:0] OP_JP      = 4'h1;
    localparam logic [3:0] OP_CALL    = 4'h2;
    localparam logic [3:0] OP_SE_IMM  = 4'h3;
    localparam logic [3:0] OP_SNE_IMM = 4'h4;
    localparam logic [3:0] OP_SE_REG  = 4'h5;
    localparam logic [3:0] OP_LD_IMM  = 4'h6;
    localparam logic [3:0] OP_ADD_IMM = 4'h7;
    localparam logic [3:0] OP_ALU     = 4'h8;
    localparam logic [3:0] OP_SNE_REG = 4'h9;

    // ALU group sub-operations (low nibble).
    localparam logic [3:0] ALU_LD   = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_OVERFLOW    = 2'd2,
        ST_UNDERFLOW   = 2'd3
    } t_status;

    // Machine state seen by the execute logic.
    typedef struct packed {
        logic [PC_W-1:0]  pc;
        logic [REG_W-1:0] vx;
        logic [REG_W-1:0] vy;
        logic [PC_W-1:0]  tos;
        logic             stack_empty;
        logic             stack_full;
    } t_exec_ctx;

    // Result and state updates produced by the execute logic.
    typedef struct packed {
        logic [PC_W-1:0]  next_pc;
        logic             clear_screen;
        t_status          status;
        logic             reg_we;
        logic [REG_W-1:0] reg_wdata;
        logic             vf_we;
        logic [REG_W-1:0] vf_wdata;
        logic             push;
        logic             pop;
    } t_exec_res;

endpackage

FILE: src/c8ie_if.sv
interface c8ie_in_if import c8ie_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INSTR_W-1:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface c8ie_out_if import c8ie_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [PC_W-1:0] next_pc;
    logic            clear_screen;
    logic [1:0]      status;

    modport source (output valid, output next_pc, output clear_screen, output status,
                    input ready);
    modport sink   (input valid, input next_pc, input clear_screen, input status,
                    output ready);
endinterface

FILE: src/chip8_instruction_execute_top.sv
// Executes one interpreter instruction word per handshake and returns the next program
// counter, a clear-screen strobe and a status code (ok, unsupported, stack overflow,
// stack underflow). A new instruction word is taken every clock cycle while the result
// side does not stall. Its result word passes through the input register, the single
// execute stage and the output register before it is presented. The throughput is
// set by that execute stage, which reads and updates the data registers, program counter
// and return stack for each word. Register operands are read from the register file at
// acceptance and forwarded from the instruction executing in that cycle. The return
// stack keeps its top entry in a register and the rest in a RAM, so no clearing pass is
// needed after reset.
module chip8_instruction_execute_top import c8ie_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    c8ie_in_if.sink        i_cmd,
    c8ie_out_if.source     o_res
);

    `include "chip8_instruction_execute_top_assert.svh"

    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);

    // Pipeline control.
    logic r_in_valid;
    logic r_out_valid;
    logic out_free;
    logic exec_fire;
    logic in_fire;

    logic [INSTR_W-1:0] r_in_instr;

    // Register file: V0..VE in RAM with valid bits, VF in a flip-flop.
    logic [NUM_VREGS-1:0] r_vvalid;
    logic [REG_W-1:0]     r_vf;
    logic [REG_W-1:0]     n_vf;
    logic                 r_fwd_x_hit;
    logic                 r_fwd_y_hit;
    logic [REG_W-1:0]     r_fwd_data;
    logic [REG_W-1:0]     vx_q;
    logic [REG_W-1:0]     vy_q;
    logic                 vram_we;
    logic [VIDX_W-1:0]    cur_x;
    logic [VIDX_W-1:0]    cur_y;
    logic [VIDX_W-1:0]    new_x;
    logic [VIDX_W-1:0]    new_y;
    logic [REG_W-1:0]     vx_val;
    logic [REG_W-1:0]     vy_val;

    // Program counter and return stack.
    logic [PC_W-1:0] r_pc;
    logic [DW-1:0]   r_depth;
    logic [DW-1:0]   n_depth;
    logic [DW-1:0]   wr_slot;
    logic [DW-1:0]   rd_slot;
    logic [PC_W-1:0] r_tos;
    logic [PC_W-1:0] r_byp;
    logic            r_byp_valid;
    logic [PC_W-1:0] stk_q;
    logic [PC_W-1:0] below_tos;
    logic            stk_we;

    t_exec_ctx ctx;
    t_exec_res res;

    // Output register.
    logic [PC_W-1:0] r_out_next_pc;
    logic            r_out_clear;
    t_status         r_out_status;

    assign out_free    = !r_out_valid || o_res.ready;
    assign exec_fire   = r_in_valid && out_free;
    assign i_cmd.ready = !r_in_valid || out_free;
    assign in_fire     = i_cmd.valid && i_cmd.ready;

    assign cur_x = r_in_instr[11:8];
    assign cur_y = r_in_instr[7:4];
    assign new_x = i_cmd.instruction[11:8];
    assign new_y = i_cmd.instruction[7:4];

    always_comb begin
        if (cur_x == VF_IDX) begin
            vx_val = r_vf;
        end else if (r_fwd_x_hit) begin
            vx_val = r_fwd_data;
        end else if (r_vvalid[cur_x]) begin
            vx_val = vx_q;
        end else begin
            vx_val = '0;
        end
        if (cur_y == VF_IDX) begin
            vy_val = r_vf;
        end else if (r_fwd_y_hit) begin
            vy_val = r_fwd_data;
        end else if (r_vvalid[cur_y]) begin
            vy_val = vy_q;
        end else begin
            vy_val = '0;
        end
    end

    assign stk_we    = exec_fire && res.push && (r_depth != '0);
    assign wr_slot   = r_depth - DW'(1);
    assign rd_slot   = n_depth - DW'(2);
    assign below_tos = r_byp_valid ? r_byp : stk_q;

    assign ctx.pc          = r_pc;
    assign ctx.vx          = vx_val;
    assign ctx.vy          = vy_val;
    assign ctx.tos         = r_tos;
    assign ctx.stack_empty = (r_depth == '0);
    assign ctx.stack_full  = (r_depth == DW'(STACK_DEPTH));

    c8ie_exec u_exec (
        .i_instruction (r_in_instr),
        .i_ctx         (ctx),
        .o_res         (res)
    );

    assign vram_we = exec_fire && res.reg_we && (cur_x != VF_IDX);

    always_comb begin
        n_vf = r_vf;
        if (exec_fire && res.vf_we) begin
            n_vf = res.vf_wdata;
        end else if (exec_fire && res.reg_we && (cur_x == VF_IDX)) begin
            n_vf = res.reg_wdata;
        end
    end

    always_comb begin
        n_depth = r_depth;
        if (exec_fire && res.push) begin
            n_depth = r_depth + DW'(1);
        end else if (exec_fire && res.pop) begin
            n_depth = r_depth - DW'(1);
        end
    end

    c8ie_ram #(.WIDTH(REG_W), .DEPTH(NUM_VREGS)) u_vx_ram (
        .i_clk   (i_clk),
        .i_we    (vram_we),
        .i_waddr (cur_x),
        .i_wdata (res.reg_wdata),
        .i_re    (in_fire),
        .i_raddr (new_x),
        .o_rdata (vx_q)
    );

    c8ie_ram #(.WIDTH(REG_W), .DEPTH(NUM_VREGS)) u_vy_ram (
        .i_clk   (i_clk),
        .i_we    (vram_we),
        .i_waddr (cur_x),
        .i_wdata (res.reg_wdata),
        .i_re    (in_fire),
        .i_raddr (new_y),
        .o_rdata (vy_q)
    );

    // Holds every stack entry below the top one; the entry two below the
    // next depth is read ahead so a return finds it waiting.
    c8ie_ram #(.WIDTH(PC_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (wr_slot[SAW-1:0]),
        .i_wdata (r_tos),
        .i_re    (1'b1),
        .i_raddr (rd_slot[SAW-1:0]),
        .o_rdata (stk_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_vvalid    <= '0;
            r_vf        <= '0;
            r_pc        <= PC_RESET;
            r_depth     <= '0;
            r_byp_valid <= 1'b0;
        end else begin
            if (i_cmd.ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (vram_we) begin
                r_vvalid[cur_x] <= 1'b1;
            end
            r_vf    <= n_vf;
            r_depth <= n_depth;
            if (exec_fire) begin
                r_pc <= res.next_pc;
            end
            if (exec_fire && res.push) begin
                r_byp_valid <= 1'b1;
            end else if (exec_fire && res.pop) begin
                r_byp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_instr  <= i_cmd.instruction;
            // The RAM read misses a write made in this same cycle.
            r_fwd_x_hit <= vram_we && (cur_x == new_x);
            r_fwd_y_hit <= vram_we && (cur_x == new_y);
            r_fwd_data  <= res.reg_wdata;
        end
        if (exec_fire && res.push) begin
            r_tos <= r_pc;
            r_byp <= r_tos;
        end else if (exec_fire && res.pop) begin
            r_tos <= below_tos;
        end
        if (exec_fire) begin
            r_out_next_pc <= res.next_pc;
            r_out_clear   <= res.clear_screen;
            r_out_status  <= res.status;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.next_pc      = r_out_next_pc;
    assign o_res.clear_screen = r_out_clear;
    assign o_res.status       = r_out_status;

    `C8IE_ASSERT_RST(a_depth_bound, r_depth <= DW'(STACK_DEPTH), "stack depth out of range")
    `C8IE_ASSERT_RST(a_push_depth,
        exec_fire && res.push |=> r_depth == $past(r_depth) + DW'(1),
        "call did not grow the stack")
    `C8IE_ASSERT_RST(a_fault_pc_hold,
        exec_fire && (res.status != ST_OK) |=> r_pc == $past(r_pc),
        "faulting instruction moved the program counter")
    `C8IE_ASSERT_RST(a_clear_ok,
        r_out_valid && r_out_clear |-> r_out_status == ST_OK,
        "clear screen with error status")

endmodule

FILE: src/c8ie_ram.sv
module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/c8ie_exec.sv
module c8ie_exec import c8ie_pkg::*; (
    input  logic [INSTR_W-1:0] i_instruction,
    input  t_exec_ctx          i_ctx,
    output t_exec_res          o_res
);

    logic [3:0]       grp;
    logic [3:0]       n;
    logic [REG_W-1:0] nn;
    logic [PC_W-1:0]  nnn;
    logic [PC_W-1:0]  pc_step;
    logic [PC_W-1:0]  pc_skip;
    logic [PC_W-1:0]  ret_pc;
    logic [REG_W:0]   sum;

    assign grp     = i_instruction[15:12];
    assign n       = i_instruction[3:0];
    assign nn      = i_instruction[7:0];
    assign nnn     = i_instruction[11:0];
    assign pc_step = i_ctx.pc + PC_STEP;
    assign pc_skip = i_ctx.pc + PC_SKIP;
    assign ret_pc  = i_ctx.tos + PC_STEP;
    assign sum     = {1'b0, i_ctx.vx} + {1'b0, i_ctx.vy};

    always_comb begin
        o_res         = '0;
        o_res.next_pc = i_ctx.pc;
        o_res.status  = ST_OK;
        unique case (grp)
            OP_SYS: begin
                if (i_instruction == OPC_CLS) begin
                    o_res.clear_screen = 1'b1;
                    o_res.next_pc      = pc_step;
                end else if (i_instruction == OPC_RET) begin
                    if (i_ctx.stack_empty) begin
                        o_res.status = ST_UNDERFLOW;
                    end else begin
                        o_res.pop     = 1'b1;
                        o_res.next_pc = ret_pc;
                    end
                end else begin
                    o_res.status = ST_UNSUPPORTED;
                end
            end
            OP_JP: begin
                o_res.next_pc = nnn;
            end
            OP_CALL: begin
                if (i_ctx.stack_full) begin
                    o_res.status = ST_OVERFLOW;
                end else begin
                    o_res.push    = 1'b1;
                    o_res.next_pc = nnn;
                end
            end
            OP_SE_IMM: begin
                o_res.next_pc = (i_ctx.vx == nn) ? pc_skip : pc_step;
            end
            OP_SNE_IMM: begin
                o_res.next_pc = (i_ctx.vx != nn) ? pc_skip : pc_step;
            end
            OP_SE_REG: begin
                if (n != 4'h0) begin
                    o_res.status = ST_UNSUPPORTED;
                end else begin
                    o_res.next_pc = (i_ctx.vx == i_ctx.vy) ? pc_skip : pc_step;
                end
            end
            OP_LD_IMM: begin
                o_res.reg_we    = 1'b1;
                o_res.reg_wdata = nn;
                o_res.next_pc   = pc_step;
            end
            OP_ADD_IMM: begin
                o_res.reg_we    = 1'b1;
                o_res.reg_wdata = i_ctx.vx + nn;
                o_res.next_pc   = pc_step;
            end
            OP_ALU: begin
                o_res.reg_we  = 1'b1;
                o_res.next_pc = pc_step;
                unique case (n)
                    ALU_LD:  o_res.reg_wdata = i_ctx.vy;
                    ALU_OR:  o_res.reg_wdata = i_ctx.vx | i_ctx.vy;
                    ALU_AND: o_res.reg_wdata = i_ctx.vx & i_ctx.vy;
                    ALU_XOR: o_res.reg_wdata = i_ctx.vx ^ i_ctx.vy;
                    ALU_ADD: begin
                        o_res.reg_wdata = sum[REG_W-1:0];
                        o_res.vf_we     = 1'b1;
                        o_res.vf_wdata  = {{(REG_W-1){1'b0}}, sum[REG_W]};
                    end
                    ALU_SUB: begin
                        o_res.reg_wdata = i_ctx.vx - i_ctx.vy;
                        o_res.vf_we     = 1'b1;
                        o_res.vf_wdata  = {{(REG_W-1){1'b0}}, i_ctx.vx >= i_ctx.vy};
                    end
                    ALU_SHR: begin
                        o_res.reg_wdata = {1'b0, i_ctx.vx[REG_W-1:1]};
                        o_res.vf_we     = 1'b1;
                        o_res.vf_wdata  = {{(REG_W-1){1'b0}}, i_ctx.vx[0]};
                    end
                    ALU_SUBN: begin
                        o_res.reg_wdata = i_ctx.vy - i_ctx.vx;
                        o_res.vf_we     = 1'b1;
                        o_res.vf_wdata  = {{(REG_W-1){1'b0}}, i_ctx.vy >= i_ctx.vx};
                    end
                    ALU_SHL: begin
                        o_res.reg_wdata = {i_ctx.vx[REG_W-2:0], 1'b0};
                        o_res.vf_we     = 1'b1;
                        o_res.vf_wdata  = {{(REG_W-1){1'b0}}, i_ctx.vx[REG_W-1]};
                    end
                    default: begin
                        o_res.reg_we  = 1'b0;
                        o_res.next_pc = i_ctx.pc;
                        o_res.status  = ST_UNSUPPORTED;
                    end
                endcase
            end
            OP_SNE_REG: begin
                if (n != 4'h0) begin
                    o_res.status = ST_UNSUPPORTED;
                end else begin
                    o_res.next_pc = (i_ctx.vx != i_ctx.vy) ? pc_skip : pc_step;
                end
            end
            default: begin
                o_res.status = ST_UNSUPPORTED;
            end
        endcase
    end

endmodule

FILE: tb/sv/chip8_instruction_execute_checker.sv
module chip8_instruction_execute_checker import c8ie_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    c8ie_in_if   cmd,
    c8ie_out_if  res,
    output int   o_mismatches,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PC_W-1:0] next_pc;
        logic            clear_screen;
        t_status         status;
    } t_step_outcome;

    logic [REG_W-1:0] vregs [NUM_VREGS];
    logic [PC_W-1:0]  pc_q;
    logic [PC_W-1:0]  ret_stack [STACK_DEPTH];
    int               depth;
    t_step_outcome    outcome_q [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // Runs one instruction word against the shadow machine state.
    function automatic t_step_outcome execute_word(input logic [INSTR_W-1:0] word);
        t_step_outcome    o;
        logic [3:0]       x;
        logic [3:0]       y;
        logic [3:0]       n;
        logic [REG_W-1:0] nn;
        logic [REG_W-1:0] vx;
        logic [REG_W-1:0] vy;
        logic [REG_W-1:0] alu_res;
        logic [REG_W:0]   sum;
        logic             flag;
        logic             sets_flag;

        x  = word[11:8];
        y  = word[7:4];
        n  = word[3:0];
        nn = word[7:0];
        vx = vregs[x];
        vy = vregs[y];
        alu_res   = '0;
        flag      = 1'b0;
        sets_flag = 1'b0;
        o.next_pc      = pc_q;
        o.clear_screen = 1'b0;
        o.status       = ST_OK;

        case (word[15:12])
            OP_SYS: begin
                if (word == OPC_CLS) begin
                    o.clear_screen = 1'b1;
                    o.next_pc = pc_q + PC_STEP;
                end else if (word == OPC_RET) begin
                    if (depth == 0) begin
                        o.status = ST_UNDERFLOW;
                    end else begin
                        depth--;
                        o.next_pc = ret_stack[depth] + PC_STEP;
                    end
                end else begin
                    o.status = ST_UNSUPPORTED;
                end
            end
            OP_JP: o.next_pc = word[11:0];
            OP_CALL: begin
                if (depth >= STACK_DEPTH) begin
                    o.status = ST_OVERFLOW;
                end else begin
                    ret_stack[depth] = pc_q;
                    depth++;
                    o.next_pc = word[11:0];
                end
            end
            OP_SE_IMM:  o.next_pc = pc_q + ((vx == nn) ? PC_SKIP : PC_STEP);
            OP_SNE_IMM: o.next_pc = pc_q + ((vx != nn) ? PC_SKIP : PC_STEP);
            OP_SE_REG: begin
                if (n != 4'h0) o.status = ST_UNSUPPORTED;
                else o.next_pc = pc_q + ((vx == vy) ? PC_SKIP : PC_STEP);
            end
            OP_SNE_REG: begin
                if (n != 4'h0) o.status = ST_UNSUPPORTED;
                else o.next_pc = pc_q + ((vx != vy) ? PC_SKIP : PC_STEP);
            end
            OP_LD_IMM: begin
                vregs[x] = nn;
                o.next_pc = pc_q + PC_STEP;
            end
            OP_ADD_IMM: begin
                vregs[x] = vx + nn;
                o.next_pc = pc_q + PC_STEP;
            end
            OP_ALU: begin
                o.next_pc = pc_q + PC_STEP;
                case (n)
                    ALU_LD:  vregs[x] = vy;
                    ALU_OR:  vregs[x] = vx | vy;
                    ALU_AND: vregs[x] = vx & vy;
                    ALU_XOR: vregs[x] = vx ^ vy;
                    ALU_ADD: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        alu_res = sum[REG_W-1:0];
                        flag = sum[REG_W];
                        sets_flag = 1'b1;
                    end
                    ALU_SUB: begin
                        alu_res = vx - vy;
                        flag = (vx >= vy);
                        sets_flag = 1'b1;
                    end
                    ALU_SHR: begin
                        alu_res = vx >> 1;
                        flag = vx[0];
                        sets_flag = 1'b1;
                    end
                    ALU_SUBN: begin
                        alu_res = vy - vx;
                        flag = (vy >= vx);
                        sets_flag = 1'b1;
                    end
                    ALU_SHL: begin
                        alu_res = vx << 1;
                        flag = vx[REG_W-1];
                        sets_flag = 1'b1;
                    end
                    default: begin
                        o.status = ST_UNSUPPORTED;
                        o.next_pc = pc_q;
                    end
                endcase
                // The flag lands after the result, so it wins when X is VF.
                if (sets_flag) begin
                    vregs[x] = alu_res;
                    vregs[VF_IDX] = {{(REG_W-1){1'b0}}, flag};
                end
            end
            default: o.status = ST_UNSUPPORTED;
        endcase

        pc_q = o.next_pc;
        return o;
    endfunction

    task automatic note_failure(input string what);
        o_mismatches++;
        if (o_mismatches <= 10) $display("%0t: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        t_step_outcome want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VREGS; i++) vregs[i] = '0;
            for (int i = 0; i < STACK_DEPTH; i++) ret_stack[i] = '0;
            pc_q  = PC_RESET;
            depth = 0;
            outcome_q.delete();
        end else begin
            // Check the outgoing word first so a result can never match an
            // expectation pushed in the same cycle.
            if (res.valid && res.ready) begin
                if (outcome_q.size() == 0) begin
                    note_failure($sformatf("unexpected result pc=%03h clr=%0b status=%0d",
                                           res.next_pc, res.clear_screen, res.status));
                end else begin
                    want = outcome_q.pop_front();
                    if (res.next_pc !== want.next_pc ||
                        res.clear_screen !== want.clear_screen ||
                        res.status !== want.status) begin
                        note_failure($sformatf(
                            "expected pc=%03h clr=%0b status=%0d, got pc=%03h clr=%0b status=%0d",
                            want.next_pc, want.clear_screen, want.status,
                            res.next_pc, res.clear_screen, res.status));
                    end
                end
            end
            if (cmd.valid && cmd.ready) outcome_q.push_back(execute_word(cmd.instruction));
        end
        o_outstanding = outcome_q.size();
    end

endmodule

FILE: tb/sv/chip8_instruction_execute_top_tb.sv
module chip8_instruction_execute_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import c8ie_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int NUM_RANDOM  = 1000;
    localparam int NUM_DIRECTED = 33;

    localparam logic [INSTR_W-1:0] DIRECTED [NUM_DIRECTED] = '{
        OPC_CLS,
        OPC_RET,                              // return with nothing pushed
        {OP_SYS, 12'h123},
        {OP_LD_IMM, 4'hA, 8'hFF},
        {OP_LD_IMM, 4'hB, 8'h01},
        {OP_ALU, 4'hA, 4'hB, ALU_ADD},        // carry out
        {OP_ADD_IMM, 4'hA, 8'hFF},
        {OP_ALU, 4'hA, 4'hB, ALU_SUB},
        {OP_ALU, 4'hA, 4'hB, ALU_SUBN},       // borrow
        {OP_ALU, 4'hA, 4'hB, ALU_SHR},
        {OP_ALU, 4'hA, 4'hB, ALU_SHL},
        {OP_ALU, 4'hF, 4'hA, ALU_ADD},        // flag overwrites the result in VF
        {OP_ALU, 4'hC, 4'hA, ALU_LD},
        {OP_ALU, 4'hC, 4'hB, ALU_OR},
        {OP_ALU, 4'hC, 4'hA, ALU_AND},
        {OP_ALU, 4'hC, 4'hB, ALU_XOR},
        {OP_ALU, 4'hA, 4'hB, 4'hF},
        {OP_SE_IMM, 4'h0, 8'h00},
        {OP_SNE_IMM, 4'h0, 8'h00},
        {OP_SE_REG, 4'h0, 4'h1, 4'h0},
        {OP_SNE_REG, 4'h0, 4'h1, 4'h0},
        {OP_SE_REG, 4'h0, 4'h1, 4'h1},
        {OP_SNE_REG, 4'h0, 4'h1, 4'h8},
        {OP_JP, 12'hFFE},
        {OP_CALL, 12'h300},
        OPC_RET,                              // resumes past the top of memory
        {OP_JP, 12'hFFE},
        {OP_SE_IMM, 4'h0, 8'h00},             // taken skip wraps around
        {OP_JP, 12'h000},
        {OP_LD_IMM, 4'h5, 8'h80},
        {OP_ALU, 4'h5, 4'h5, ALU_SHL},
        16'hF000,
        16'hA123
    };

    localparam logic [3:0] ALU_CODES [9] = '{
        ALU_LD, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL
    };

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   outstanding;
    int   idle_max;
    int   sent;

    c8ie_in_if  cmd_if ();
    c8ie_out_if res_if ();

    chip8_instruction_execute_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    chip8_instruction_execute_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .cmd           (cmd_if),
        .res           (res_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2ms;
        $display("chip8_instruction_execute_top_tb NOT OK");
        $finish;
    end

    // Mostly corner operand values (00, 01, FF, 80) so that skips and flags actually trigger.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'hFF;
            3: return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [INSTR_W-1:0] random_word();
        int         sel;
        logic [3:0] x;
        logic [3:0] y;
        logic [3:0] n;

        sel = $urandom_range(0, 99);
        x = 4'($urandom_range(0, 15));
        y = 4'($urandom_range(0, 15));
        n = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(1, 15)) : 4'h0;
        if (sel < 10) return INSTR_W'($urandom_range(0, 65535));
        if (sel < 14) return OPC_CLS;
        if (sel < 20) return OPC_RET;
        if (sel < 28) return {OP_CALL, 12'($urandom_range(0, 4095))};
        if (sel < 33) return {OP_JP, 12'($urandom_range(0, 4095))};
        if (sel < 40) return {OP_SE_IMM, x, pick_byte()};
        if (sel < 46) return {OP_SNE_IMM, x, pick_byte()};
        if (sel < 52) return {OP_SE_REG, x, y, n};
        if (sel < 58) return {OP_SNE_REG, x, y, n};
        if (sel < 66) return {OP_LD_IMM, x, pick_byte()};
        if (sel < 72) return {OP_ADD_IMM, x, pick_byte()};
        if ($urandom_range(0, 6) == 0) return {OP_ALU, x, y, 4'($urandom_range(0, 15))};
        return {OP_ALU, x, y, ALU_CODES[$urandom_range(0, 8)]};
    endfunction

    task automatic send_word(input logic [INSTR_W-1:0] word);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.instruction <= word;
        do @(posedge i_clk); while (!cmd_if.ready);
        @(negedge i_clk);
        sent++;
    endtask

    // Result side: holds ready low for a random idle gap, bounded by idle_max, before each word.
    initial begin
        int stall;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = $urandom_range(0, idle_max);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
            @(negedge i_clk);
        end
    end

    initial begin
        int  burst;
        int  next_mode_at;
        bit  drained;

        cmd_if.valid       = 1'b0;
        cmd_if.instruction = '0;
        i_rst_n  = 1'b0;
        idle_max = 5;
        sent     = 0;
        drained  = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) send_word(DIRECTED[i]);

        sent = 0;
        next_mode_at = 0;
        while (sent < NUM_RANDOM) begin
            if (sent >= next_mode_at) begin
                idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
                next_mode_at += 100;
            end
            if (!drained && sent >= NUM_RANDOM / 2) begin
                cmd_if.valid <= 1'b0;
                while (outstanding != 0) @(negedge i_clk);
                drained = 1'b1;
            end
            if ($urandom_range(0, 99) < 4) begin
                // Deep call chain then unwind, which can run into both stack limits.
                burst = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
                repeat (burst) send_word({OP_CALL, 12'($urandom_range(0, 4095))});
                repeat ($urandom_range(0, 3)) send_word(random_word());
                burst = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
                repeat (burst) send_word(OPC_RET);
            end else begin
                send_word(random_word());
            end
        end
        cmd_if.valid <= 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("chip8_instruction_execute_top_tb OK");
        end else begin
            $display("chip8_instruction_execute_top_tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/c8ie_pkg.sv
src/c8ie_if.sv
src/c8ie_ram.sv
src/c8ie_exec.sv
src/chip8_instruction_execute_top.sv
tb/sv/chip8_instruction_execute_checker.sv
tb/sv/chip8_instruction_execute_top_tb.sv
